[src/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define LBP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lbp assertion failed");

// Checked at every edge, reset included.
`define LBP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("lbp assertion failed");

`endif

[src/lbp_pkg.sv]
// ---------------------------------------------------------------------------
// lbp_pkg
// Types, constants and the quarter sine table of the beam to pixel mapper.
// ---------------------------------------------------------------------------
`default_nettype none

package lbp_pkg;

  localparam int BEAM_COUNT = 360;
  localparam int IMG_WIDTH  = 400;
  localparam int IMG_HEIGHT = 400;

  localparam int BEAM_W   = 9;
  localparam int RANGE_W  = 16;
  localparam int ANGLE_W  = 16;
  localparam int PIX_W    = 9;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W    = 16;

  localparam int MAG_W  = 15;
  localparam int DIFF_W = 11;
  localparam int FRAC_W = 9;
  localparam int P1_W   = MAG_W + RANGE_W;
  localparam int P2_W   = P1_W + CFG_W;
  localparam int Q_W    = P2_W - 31 + 1;
  localparam int SUM_W  = Q_W + 2;

  localparam logic [PIX_W-1:0] COL_CENTER = PIX_W'(IMG_WIDTH / 2);
  localparam logic [PIX_W-1:0] COL_LAST   = PIX_W'(IMG_WIDTH - 1);
  localparam logic [PIX_W-1:0] ROW_BOTTOM = PIX_W'(IMG_HEIGHT - 1);
  localparam logic [PIX_W-1:0] ROW_LAST   = PIX_W'(IMG_HEIGHT - 1);

  localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'h4000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANGLE_START = 2'd0,
    REG_ANGLE_STEP  = 2'd1,
    REG_MAX_RANGE   = 2'd2,
    REG_SCALE       = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [BEAM_W-1:0]  beam_index;
    logic [RANGE_W-1:0] range_mm;
  } in_beat_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_row;
    logic [PIX_W-1:0] pixel_col;
  } out_beat_t;

  typedef struct packed {
    logic [CFG_W-1:0] angle_start;
    logic [CFG_W-1:0] angle_step;
    logic [CFG_W-1:0] max_range_mm;
    logic [CFG_W-1:0] scale_q16;
  } cfg_t;

  function automatic logic [MAG_W-1:0] sine_tab(input logic [5:0] k);
    logic [MAG_W-1:0] v;
    unique case (k)
      6'd0:  v = 15'd0;
      6'd1:  v = 15'd1608;
      6'd2:  v = 15'd3212;
      6'd3:  v = 15'd4808;
      6'd4:  v = 15'd6393;
      6'd5:  v = 15'd7962;
      6'd6:  v = 15'd9512;
      6'd7:  v = 15'd11039;
      6'd8:  v = 15'd12540;
      6'd9:  v = 15'd14010;
      6'd10: v = 15'd15447;
      6'd11: v = 15'd16846;
      6'd12: v = 15'd18205;
      6'd13: v = 15'd19520;
      6'd14: v = 15'd20788;
      6'd15: v = 15'd22006;
      6'd16: v = 15'd23170;
      6'd17: v = 15'd24279;
      6'd18: v = 15'd25330;
      6'd19: v = 15'd26320;
      6'd20: v = 15'd27245;
      6'd21: v = 15'd28106;
      6'd22: v = 15'd28898;
      6'd23: v = 15'd29622;
      6'd24: v = 15'd30273;
      6'd25: v = 15'd30853;
      6'd26: v = 15'd31357;
      6'd27: v = 15'd31786;
      6'd28: v = 15'd32138;
      6'd29: v = 15'd32413;
      6'd30: v = 15'd32610;
      6'd31: v = 15'd32729;
      default: v = 15'd32767;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[src/lbp_angle.sv]
// ---------------------------------------------------------------------------
// lbp_angle
// Two stages: beam angle from index and step with the index and range drop
// decision, then the mirrored sine and cosine angles with the half-turn drop decision.
// ---------------------------------------------------------------------------
`default_nettype none

module lbp_angle (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            adv,
  input  wire logic                            in_valid,
  input  wire lbp_pkg::in_beat_t               in_data,
  input  wire lbp_pkg::cfg_t                   cfg,
  output logic                                 ang_valid,
  output logic [lbp_pkg::ANGLE_W-1:0]          sin_ang,
  output logic [lbp_pkg::ANGLE_W-1:0]          cos_ang,
  output logic [lbp_pkg::RANGE_W-1:0]          ang_range
);
  import lbp_pkg::*;

  localparam logic [BEAM_W-1:0] BEAM_LIM = BEAM_W'(BEAM_COUNT);

  logic                 v1_r, v1_nxt;
  logic [ANGLE_W-1:0]   angle_r, angle_nxt;
  logic [RANGE_W-1:0]   range1_r;
  logic                 v2_r, v2_nxt;
  logic [ANGLE_W-1:0]   sin_r, sin_nxt;
  logic [ANGLE_W-1:0]   cos_r, cos_nxt;
  logic [RANGE_W-1:0]   range2_r;
  logic [BEAM_W+ANGLE_W-1:0] step_prod;

  always_comb begin
    step_prod = (BEAM_W+ANGLE_W)'(in_data.beam_index) * (BEAM_W+ANGLE_W)'(cfg.angle_step);
    angle_nxt = step_prod[ANGLE_W-1:0] + cfg.angle_start;
    v1_nxt    = in_valid && (in_data.beam_index < BEAM_LIM) &&
                (in_data.range_mm <= cfg.max_range_mm);
    sin_nxt   = QUARTER_TURN - angle_r;
    cos_nxt   = sin_nxt + QUARTER_TURN;
    v2_nxt    = v1_r && ((sin_nxt == '0) || sin_nxt[ANGLE_W-1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      angle_r  <= angle_nxt;
      range1_r <= in_data.range_mm;
      sin_r    <= sin_nxt;
      cos_r    <= cos_nxt;
      range2_r <= range1_r;
    end
  end

  assign ang_valid = v2_r;
  assign sin_ang   = sin_r;
  assign cos_ang   = cos_r;
  assign ang_range = range2_r;

endmodule

`default_nettype wire

[src/lbp_sine.sv]
// ---------------------------------------------------------------------------
// lbp_sine
// Two-stage Q1.15 sine: quadrant fold and table fetch, then interpolation.
// ---------------------------------------------------------------------------
`default_nettype none

module lbp_sine (
  input  wire logic                         clk,
  input  wire logic                         adv,
  input  wire logic [lbp_pkg::ANGLE_W-1:0]  ang,
  output logic [lbp_pkg::MAG_W-1:0]         mag,
  output logic                              neg
);
  import lbp_pkg::*;

  logic [1:0]          quad;
  logic [MAG_W-1:0]    p;
  logic [5:0]          k;
  logic [MAG_W-1:0]    base_r, base_nxt;
  logic [MAG_W-1:0]    next_val;
  logic [DIFF_W-1:0]   diff_r, diff_nxt;
  logic [FRAC_W-1:0]   frac_r;
  logic                neg1_r;
  logic [DIFF_W+FRAC_W-1:0] interp;
  logic [MAG_W-1:0]    mag_r, mag_nxt;
  logic                neg2_r;

  always_comb begin
    quad     = ang[ANGLE_W-1 -: 2];
    p        = quad[0] ? MAG_W'(QUARTER_TURN[MAG_W-1:0] - {1'b0, ang[13:0]})
                       : {1'b0, ang[13:0]};
    k        = p[MAG_W-1:FRAC_W];
    base_nxt = sine_tab(k);
    next_val = sine_tab(6'(k + 6'd1));
    diff_nxt = DIFF_W'(next_val - base_nxt);
    interp   = (DIFF_W+FRAC_W)'(diff_r) * (DIFF_W+FRAC_W)'(frac_r);
    mag_nxt  = base_r + MAG_W'(interp[DIFF_W+FRAC_W-1:FRAC_W]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      base_r <= base_nxt;
      diff_r <= diff_nxt;
      frac_r <= p[FRAC_W-1:0];
      neg1_r <= quad[1];
      mag_r  <= mag_nxt;
      neg2_r <= neg1_r;
    end
  end

  assign mag = mag_r;
  assign neg = neg2_r;

endmodule

`default_nettype wire

[src/lbp_scale.sv]
// ---------------------------------------------------------------------------
// lbp_scale
// Three stages: sine times range, times pixel scale, then floor, offset and
// clamp to the image edge.
// ---------------------------------------------------------------------------
`default_nettype none

module lbp_scale (
  input  wire logic                         clk,
  input  wire logic                         adv,
  input  wire logic [lbp_pkg::MAG_W-1:0]    mag,
  input  wire logic                         neg,
  input  wire logic [lbp_pkg::RANGE_W-1:0]  range_mm,
  input  wire logic [lbp_pkg::CFG_W-1:0]    scale_q16,
  input  wire logic [lbp_pkg::PIX_W-1:0]    offset,
  input  wire logic [lbp_pkg::PIX_W-1:0]    last,
  output logic [lbp_pkg::PIX_W-1:0]         pix
);
  import lbp_pkg::*;

  localparam logic [P2_W:0] ROUND_UP = (P2_W+1)'(32'h7FFF_FFFF);

  logic [P1_W-1:0]  p1_r, p1_nxt;
  logic             neg1_r;
  logic [P2_W-1:0]  p2_r, p2_nxt;
  logic             neg2_r;
  logic [P2_W:0]    rounded;
  logic [Q_W-1:0]   q;
  logic [SUM_W-1:0] sum;
  logic [PIX_W-1:0] pix_r, pix_nxt;

  always_comb begin
    p1_nxt  = P1_W'(mag) * P1_W'(range_mm);
    p2_nxt  = P2_W'(p1_r) * P2_W'(scale_q16);
    rounded = {1'b0, p2_r} + ROUND_UP;
    q       = neg2_r ? rounded[P2_W:31] : {1'b0, p2_r[P2_W-1:31]};
    sum     = neg2_r ? SUM_W'(offset) - SUM_W'(q) : SUM_W'(offset) + SUM_W'(q);
    if (sum[SUM_W-1]) begin
      pix_nxt = '0;
    end else if (sum[SUM_W-2:0] > (SUM_W-1)'(last)) begin
      pix_nxt = last;
    end else begin
      pix_nxt = sum[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r   <= p1_nxt;
      neg1_r <= neg;
      p2_r   <= p2_nxt;
      neg2_r <= neg1_r;
      pix_r  <= pix_nxt;
    end
  end

  assign pix = pix_r;

endmodule

`default_nettype wire

[src/lidar_beam_to_pixel_core.sv]
// ---------------------------------------------------------------------------
// lidar_beam_to_pixel_core
// Maps one lidar beam (index, range) to one image pixel or drops it.
//
//   Channel  Handshake            Beat
//   in       in_valid / in_stall  in_data   (beam_index, range_mm)
//   out      out_valid / out_stall out_data (pixel_row, pixel_col)
//   cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One beat is accepted per cycle while in_stall is low.
// The depth is set by two angle stages, two sine stages and three stages of
// multiply, multiply and floor-clamp.
// A synchronous reset clears all valid bits and loads the register defaults.
// The whole pipeline holds only while a result beat waits under out_stall.
// ---------------------------------------------------------------------------
`default_nettype none

module lidar_beam_to_pixel_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire lbp_pkg::in_beat_t              in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output lbp_pkg::out_beat_t                  out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [lbp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lbp_pkg::CFG_W-1:0]      cfg_data
);
  import lbp_pkg::*;

  cfg_t               cfg_r;
  logic               adv;
  logic               ang_valid;
  logic [ANGLE_W-1:0] sin_ang;
  logic [ANGLE_W-1:0] cos_ang;
  logic [RANGE_W-1:0] ang_range;
  logic [MAG_W-1:0]   sin_mag;
  logic               sin_neg;
  logic [MAG_W-1:0]   cos_mag;
  logic               cos_neg;
  logic [RANGE_W-1:0] range_d_r [2];
  logic [4:0]         valid_r, valid_nxt;
  logic [PIX_W-1:0]   row_pix;
  logic [PIX_W-1:0]   col_pix;

  assign adv       = !(valid_r[4] && out_stall);
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.angle_start  <= 16'd32951;
      cfg_r.angle_step   <= 16'd182;
      cfg_r.max_range_mm <= 16'd3000;
      cfg_r.scale_q16    <= 16'd4369;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_ANGLE_START: cfg_r.angle_start  <= cfg_data;
        REG_ANGLE_STEP:  cfg_r.angle_step   <= cfg_data;
        REG_MAX_RANGE:   cfg_r.max_range_mm <= cfg_data;
        REG_SCALE:       cfg_r.scale_q16    <= cfg_data;
      endcase
    end
  end

  lbp_angle u_angle (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .ang_valid (ang_valid),
    .sin_ang   (sin_ang),
    .cos_ang   (cos_ang),
    .ang_range (ang_range)
  );

  lbp_sine u_sin (
    .clk (clk),
    .adv (adv),
    .ang (sin_ang),
    .mag (sin_mag),
    .neg (sin_neg)
  );

  lbp_sine u_cos (
    .clk (clk),
    .adv (adv),
    .ang (cos_ang),
    .mag (cos_mag),
    .neg (cos_neg)
  );

  assign valid_nxt = {valid_r[3:0], ang_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (adv) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      range_d_r[0] <= ang_range;
      range_d_r[1] <= range_d_r[0];
    end
  end

  lbp_scale u_row (
    .clk       (clk),
    .adv       (adv),
    .mag       (sin_mag),
    .neg       (sin_neg),
    .range_mm  (range_d_r[1]),
    .scale_q16 (cfg_r.scale_q16),
    .offset    (ROW_BOTTOM),
    .last      (ROW_LAST),
    .pix       (row_pix)
  );

  lbp_scale u_col (
    .clk       (clk),
    .adv       (adv),
    .mag       (cos_mag),
    .neg       (cos_neg),
    .range_mm  (range_d_r[1]),
    .scale_q16 (cfg_r.scale_q16),
    .offset    (COL_CENTER),
    .last      (COL_LAST),
    .pix       (col_pix)
  );

  assign out_valid          = valid_r[4];
  assign out_data.pixel_row = row_pix;
  assign out_data.pixel_col = col_pix;

endmodule

`default_nettype wire

[src/lbp_checker.sv]
// ---------------------------------------------------------------------------
// lbp_checker
// Port-level checks of the beam to pixel mapper, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lbp_checker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  input  wire logic                           in_stall,
  input  wire lbp_pkg::in_beat_t              in_data,
  input  wire logic                           out_valid,
  input  wire logic                           out_stall,
  input  wire lbp_pkg::out_beat_t             out_data,
  input  wire logic                           cfg_valid,
  input  wire logic                           cfg_ready,
  input  wire logic [lbp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lbp_pkg::CFG_W-1:0]      cfg_data
);
  import lbp_pkg::*;

  logic unused_ok;
  assign unused_ok = in_valid ^ (^in_data) ^ cfg_valid ^ cfg_ready ^ (^cfg_index) ^ (^cfg_data);

  `LBP_ASSERT(a_out_hold, clk, rst_n, (out_valid && out_stall) |=> out_valid)

  `LBP_ASSERT(a_pixel_range, clk, rst_n, out_valid |-> ((out_data.pixel_row <= ROW_LAST) && (out_data.pixel_col <= COL_LAST)))

  `LBP_ASSERT(a_stall_from_output, clk, rst_n, in_stall |-> (out_valid && out_stall))

  `LBP_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)

endmodule

bind lidar_beam_to_pixel_core lbp_checker u_lbp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .cfg_index (cfg_index),
  .cfg_data  (cfg_data)
);

`default_nettype wire

[tb/lidar_beam_to_pixel_core_test.sv]
// ---------------------------------------------------------------------------
// lidar_beam_to_pixel_core_test
// Self-checking bench for the beam to pixel mapper. Each accepted beam goes
// through a local fixed-point model of the scan geometry. Kept beams queue an
// expected pixel, and every result beat is checked against the oldest one.
// Directed beams cover the scan limits, the range limit, the mirror
// boundaries and clamping. Random scans then run under several register
// settings, with sender gaps and receiver stalls.
// ---------------------------------------------------------------------------
module lidar_beam_to_pixel_core_test;
  import lbp_pkg::*;

  localparam int PIPE_DEPTH   = 7;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_BEAMS = 1900;
  localparam int SCAN_PHASES  = 6;
  localparam int MAX_REPORTS  = 10;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_beat_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_beat_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  int sine_points [33] = '{
    0, 1608, 3212, 4808, 6393, 7962, 9512, 11039,
    12540, 14010, 15447, 16846, 18205, 19520, 20788, 22006,
    23170, 24279, 25330, 26320, 27245, 28106, 28898, 29622,
    30273, 30853, 31357, 31786, 32138, 32413, 32610, 32729,
    32767
  };

  cfg_t      scan_cfg;
  out_beat_t expected_pixels[$];
  out_beat_t pixel_due;

  int cycle_count    = 0;
  int mismatches     = 0;
  int pixels_checked = 0;
  int beams_sent     = 0;
  int beams_dropped  = 0;
  int reg_writes     = 0;
  int burst_left     = 0;
  int gap_max        = 0;
  int stall_pct      = 0;
  int stall_hold     = 0;

  lidar_beam_to_pixel_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timed out after %0d cycles with %0d pixels pending.", CYCLE_LIMIT,
             expected_pixels.size());
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (stall_pct == 0) begin
      out_stall <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      out_stall <= ($urandom_range(1, 100) <= stall_pct);
      stall_hold <= $urandom_range(0, 3);
    end
  end

  // Q1.15 sine of a binary angle, interpolated between 33 table points over a quarter turn.
  function automatic int beam_sine(input logic [ANGLE_W-1:0] a);
    logic [1:0] quad;
    int p;
    int k;
    int frac;
    int v;
    quad = a[15:14];
    p = a[13:0];
    if (quad[0]) begin
      p = 16384 - p;
    end
    k = p >> 9;
    frac = p & 511;
    if (k >= 32) begin
      v = sine_points[32];
    end else begin
      v = sine_points[k] + (((sine_points[k+1] - sine_points[k]) * frac) >> 9);
    end
    return quad[1] ? -v : v;
  endfunction

  function automatic longint pixel_offset(input int s, input logic [RANGE_W-1:0] range_mm);
    longint unsigned mag;
    mag = (s < 0) ? -s : s;
    mag = mag * range_mm;
    mag = mag * scan_cfg.scale_q16;
    if (s < 0) begin
      return -longint'((mag + 64'h7FFF_FFFF) >> 31);
    end
    return longint'(mag >> 31);
  endfunction

  function automatic logic [PIX_W-1:0] clamp_to_image(input longint v, input int dim);
    if (v < 0) begin
      v = 0;
    end
    if (v > dim - 1) begin
      v = dim - 1;
    end
    return PIX_W'(v);
  endfunction

  function automatic bit map_beam(input in_beat_t b, output out_beat_t px);
    logic [ANGLE_W-1:0] angle;
    logic [ANGLE_W-1:0] mirrored;
    logic [ANGLE_W-1:0] cos_angle;
    longint row;
    longint col;
    px = '0;
    if (b.beam_index >= BEAM_COUNT) begin
      return 1'b0;
    end
    angle = scan_cfg.angle_start + b.beam_index * scan_cfg.angle_step;
    mirrored = QUARTER_TURN - angle;
    if (mirrored != 0 && !mirrored[15]) begin
      return 1'b0;
    end
    if (b.range_mm > scan_cfg.max_range_mm) begin
      return 1'b0;
    end
    cos_angle = mirrored + QUARTER_TURN;
    col = IMG_WIDTH / 2 + pixel_offset(beam_sine(cos_angle), b.range_mm);
    row = IMG_HEIGHT - 1 + pixel_offset(beam_sine(mirrored), b.range_mm);
    px.pixel_row = clamp_to_image(row, IMG_HEIGHT);
    px.pixel_col = clamp_to_image(col, IMG_WIDTH);
    return 1'b1;
  endfunction

  task automatic flag_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("Mismatch on %0s at cycle %0d: expected %0d, got %0d", what, cycle_count,
               want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        flag_mismatch("unexpected pixel_row", -1, out_data.pixel_row);
      end else begin
        pixel_due = expected_pixels.pop_front();
        pixels_checked++;
        if (out_data.pixel_row !== pixel_due.pixel_row) begin
          flag_mismatch("pixel_row", pixel_due.pixel_row, out_data.pixel_row);
        end
        if (out_data.pixel_col !== pixel_due.pixel_col) begin
          flag_mismatch("pixel_col", pixel_due.pixel_col, out_data.pixel_col);
        end
      end
    end
  end

  task automatic send_beam(input in_beat_t b);
    out_beat_t px;
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      if (gap_max > 0) begin
        gap = $urandom_range(0, gap_max);
      end
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    beams_sent++;
    if (map_beam(b, px)) begin
      expected_pixels.push_back(px);
    end else begin
      beams_dropped++;
    end
  endtask

  task automatic send_pair(input int beam, input int range_mm);
    in_beat_t b;
    b.beam_index = BEAM_W'(beam);
    b.range_mm = RANGE_W'(range_mm);
    send_beam(b);
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 5) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ANGLE_START: scan_cfg.angle_start = val;
      REG_ANGLE_STEP:  scan_cfg.angle_step = val;
      REG_MAX_RANGE:   scan_cfg.max_range_mm = val;
      REG_SCALE:       scan_cfg.scale_q16 = val;
    endcase
    reg_writes++;
  endtask

  task automatic set_config(input int start, input int step, input int range_limit,
                            input int scale);
    quiesce();
    write_reg(REG_ANGLE_START, CFG_W'(start));
    write_reg(REG_ANGLE_STEP, CFG_W'(step));
    write_reg(REG_MAX_RANGE, CFG_W'(range_limit));
    write_reg(REG_SCALE, CFG_W'(scale));
    cfg_valid <= 1'b0;
  endtask

  function automatic in_beat_t random_beam();
    in_beat_t b;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      b.beam_index = BEAM_W'($urandom_range(BEAM_COUNT, 511));
    end else begin
      b.beam_index = BEAM_W'($urandom_range(0, BEAM_COUNT - 1));
    end
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      b.range_mm = RANGE_W'($urandom_range(0, scan_cfg.max_range_mm));
    end else if (pick < 88) begin
      b.range_mm = scan_cfg.max_range_mm;
    end else begin
      b.range_mm = RANGE_W'($urandom_range(0, 65535));
    end
    return b;
  endfunction

  task automatic test_reset_defaults();
    gap_max = 0;
    stall_pct = 0;
    send_pair(0, 0);
    send_pair(0, 3000);
    send_pair(0, 3001);
    send_pair(255, 1500);
    send_pair(359, 65535);
    send_pair(359, 2999);
    send_pair(BEAM_COUNT, 100);
    send_pair(511, 100);
    quiesce();
  endtask

  task automatic test_mirror_boundaries();
    int i;
    set_config(16380, 1, 3000, 4369);
    for (i = 2; i <= 6; i++) begin
      send_pair(i, 3000);
    end
    set_config(49148, 1, 3000, 4369);
    for (i = 2; i <= 6; i++) begin
      send_pair(i, 2000);
    end
    quiesce();
  endtask

  task automatic test_range_and_scale_extremes();
    set_config(49152, 65535, 65535, 65535);
    send_pair(0, 65535);
    send_pair(1, 65535);
    send_pair(359, 65535);
    send_pair(200, 0);
    set_config(16384, 0, 65535, 65535);
    send_pair(0, 65535);
    set_config(32768, 0, 0, 0);
    send_pair(5, 0);
    send_pair(5, 1);
    quiesce();
  endtask

  task automatic test_random_scans();
    int phase;
    int n;
    int per_phase;
    per_phase = RANDOM_BEAMS / SCAN_PHASES;
    for (phase = 0; phase < SCAN_PHASES; phase++) begin
      case (phase)
        0: begin
          set_config(32951, 182, 3000, 4369);
          gap_max = 0;
          stall_pct = 0;
        end
        1: begin
          set_config($urandom_range(0, 65535), 182, 3000, 4369);
          gap_max = 4;
          stall_pct = 30;
        end
        2: begin
          set_config($urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 65535), $urandom_range(0, 65535));
          gap_max = 8;
          stall_pct = 60;
        end
        3: begin
          set_config($urandom_range(0, 65535), 65535, 65535, 65535);
          gap_max = 2;
          stall_pct = 20;
        end
        4: begin
          set_config($urandom_range(0, 65535), $urandom_range(1, 512), 200, 65535);
          gap_max = 0;
          stall_pct = 80;
        end
        default: begin
          set_config(0, $urandom_range(0, 65535), $urandom_range(0, 65535), 0);
          gap_max = 6;
          stall_pct = 0;
        end
      endcase
      for (n = 0; n < per_phase; n++) begin
        if (phase == 2 && n == per_phase / 2) begin
          quiesce();
        end
        send_beam(random_beam());
      end
    end
    quiesce();
    stall_pct = 0;
  endtask

  initial begin
    scan_cfg = '{angle_start: 16'd32951, angle_step: 16'd182,
                 max_range_mm: 16'd3000, scale_q16: 16'd4369};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_mirror_boundaries();
    test_range_and_scale_extremes();
    test_random_scans();
    quiesce();
    $display("Sent %0d beams across %0d register writes; %0d pixels checked, %0d dropped.",
             beams_sent, reg_writes, pixels_checked, beams_dropped);
    $display("Covered scan and range limits, mirror edges, clamping, gaps and stalls.");
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("Total mismatches: %0d", mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
